/* sv/cma_pkg.sv */
// Shared types, constants and helper functions for the confusion matrix accumulator.
// Used by every module of the block except cma_ram; depends on nothing.
package cma_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int COUNT_WIDTH = 32;

    localparam int CLASS_W    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CELL_AW    = 2 * CLASS_W;
    localparam int CELL_DEPTH = 1 << CELL_AW;

    localparam int OUT_W   = 32;
    localparam int LABEL_W = 5;
    localparam int QUERY_W = 4;
    localparam int CFG_W   = 5;
    localparam int APB_DW  = 32;
    localparam int CFG_AW  = 3;

    localparam int CFG_RESET_INT = (MAX_CLASSES < 16) ? MAX_CLASSES : 16;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(CFG_RESET_INT);

    // Register select taken from the word address.
    localparam logic REG_ACTUAL    = 1'b0;
    localparam logic REG_PREDICTED = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [CLASS_W-1:0]     class_t;
    typedef logic [CELL_AW-1:0]     cell_addr_t;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] actual_classes;
        logic [CFG_W-1:0] predicted_classes;
    } cfg_t;

    typedef struct packed {
        logic   clear;
        logic   inc;
        class_t row_idx;
        class_t col_idx;
        logic   diag;
    } tot_cmd_t;

    typedef struct packed {
        count_t row;
        count_t col;
        count_t diag;
        count_t total;
    } tot_t;

    function automatic count_t sat_inc(input count_t c);
        return (&c) ? c : c + count_t'(1);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input count_t c);
        return OUT_W'(c);
    endfunction

    function automatic logic [CFG_W-1:0] clamp_classes(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] x;
        x = v;
        if (x == '0)
            x = CFG_W'(1);
        if (int'(x) > MAX_CLASSES)
            x = CFG_W'(MAX_CLASSES);
        return x;
    endfunction

    function automatic class_t to_class(input logic [QUERY_W-1:0] v);
        return CLASS_W'(v);
    endfunction

    function automatic cell_addr_t cell_addr(input class_t row, input class_t col);
        return {row, col};
    endfunction

endpackage

/* sv/cma_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependency.
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cma_cfg.sv */
// APB register file holding the active row and column counts.
// Depends on cma_pkg for widths, reset values and the register select codes.
module cma_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cma_pkg::CFG_AW-1:0]   paddr,
    input  logic [cma_pkg::APB_DW-1:0]   pwdata,
    output logic [cma_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output cma_pkg::cfg_t                cfg
);
    import cma_pkg::*;

    logic [CFG_W-1:0] actual_reg;
    logic [CFG_W-1:0] predicted_reg;
    logic             wr_en;
    logic             reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            actual_reg    <= CFG_RESET;
            predicted_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_ACTUAL)
                actual_reg <= clamp_classes(pwdata[CFG_W-1:0]);
            else
                predicted_reg <= clamp_classes(pwdata[CFG_W-1:0]);
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ACTUAL:    prdata = APB_DW'(actual_reg);
            REG_PREDICTED: prdata = APB_DW'(predicted_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.actual_classes    = actual_reg;
    assign cfg.predicted_classes = predicted_reg;

endmodule

/* sv/cma_totals.sv */
// Running row, column, diagonal and grand totals, each saturating on its own.
// Depends on cma_pkg for the command and result structs.
module cma_totals (
    input  logic              clk,
    input  logic              rst_n,
    input  cma_pkg::tot_cmd_t cmd,
    output cma_pkg::tot_t     tot
);
    import cma_pkg::*;

    count_t row_reg [MAX_CLASSES];
    count_t col_reg [MAX_CLASSES];
    count_t diag_reg;
    count_t total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                row_reg[i] <= '0;
                col_reg[i] <= '0;
            end
            diag_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                row_reg[i] <= '0;
                col_reg[i] <= '0;
            end
            diag_reg  <= '0;
            total_reg <= '0;
        end
        else if (cmd.inc)
        begin
            row_reg[cmd.row_idx] <= sat_inc(row_reg[cmd.row_idx]);
            col_reg[cmd.col_idx] <= sat_inc(col_reg[cmd.col_idx]);
            if (cmd.diag)
                diag_reg <= sat_inc(diag_reg);
            total_reg <= sat_inc(total_reg);
        end
    end

    assign tot.row   = row_reg[cmd.row_idx];
    assign tot.col   = col_reg[cmd.col_idx];
    assign tot.diag  = diag_reg;
    assign tot.total = total_reg;

endmodule

/* sv/confusion_matrix_accumulator_unit.sv */
// Confusion matrix accumulator: cell counts in a RAM, running totals in registers.
// A request is registered when accepted, and its result is registered once the output side is free.
// No new request is accepted until the current one has finished its cell RAM read-modify-write.
// Reset and clear zero all counts at once through per-cell valid bits; no sweep.
// Depends on cma_pkg, cma_ram, cma_cfg and cma_totals.
module confusion_matrix_accumulator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic signed [4:0]             actual_class,
    input  logic signed [4:0]             predicted_class,
    input  logic [3:0]                    query_class,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [31:0]                   cell_count,
    output logic [31:0]                   class_diagonal,
    output logic [31:0]                   row_total,
    output logic [31:0]                   column_total,
    output logic [31:0]                   diagonal_total,
    output logic [31:0]                   grand_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cma_pkg::CFG_AW-1:0]    paddr,
    input  logic [cma_pkg::APB_DW-1:0]    pwdata,
    output logic [cma_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import cma_pkg::*;

    cfg_t     cfg;
    tot_cmd_t tot_cmd;
    tot_t     tot;

    state_t   state_reg;
    state_t   state_next;

    logic                in_accept;
    logic                out_free;
    logic                finish;
    logic                ram_re;
    logic                ram_we;
    cell_addr_t          rd_addr;
    cell_addr_t          wr_addr;
    count_t              ram_rdata;
    count_t              cell_value;
    logic [CELL_DEPTH-1:0] cell_valid_reg;
    logic                valid_rd_reg;

    op_t                 op_reg;
    logic [LABEL_W-1:0]  act_reg;
    logic [LABEL_W-1:0]  pred_reg;
    logic [QUERY_W-1:0]  qry_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [OUT_W-1:0]    cell_out_reg;
    logic [OUT_W-1:0]    cdiag_out_reg;
    logic [OUT_W-1:0]    row_out_reg;
    logic [OUT_W-1:0]    col_out_reg;
    logic [OUT_W-1:0]    dtot_out_reg;
    logic [OUT_W-1:0]    gtot_out_reg;

    status_t             status_next;
    logic [OUT_W-1:0]    cell_out_next;
    logic [OUT_W-1:0]    cdiag_out_next;
    logic [OUT_W-1:0]    row_out_next;
    logic [OUT_W-1:0]    col_out_next;
    logic [OUT_W-1:0]    dtot_out_next;
    logic [OUT_W-1:0]    gtot_out_next;

    class_t              a_idx;
    class_t              p_idx;
    class_t              q_idx;
    status_t             pair_status;
    logic [CFG_W-1:0]    lim;
    logic [CFG_W-1:0]    q_ext;

    cma_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cma_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELL_DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (sat_inc(cell_value)),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    cma_totals u_totals (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tot_cmd),
        .tot   (tot)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_EXEC;
            ST_EXEC: if (out_free)  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        finish   = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_EXEC: finish   = out_free;
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // The cell read is issued from the request fields as they are accepted.
    assign ram_re = in_accept;
    always_comb
    begin
        if (op_t'(operation) == OP_QUERY)
            rd_addr = cell_addr(to_class(query_class), to_class(query_class));
        else
            rd_addr = cell_addr(to_class(actual_class[3:0]), to_class(predicted_class[3:0]));
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op_t'(operation);
            act_reg  <= $unsigned(actual_class);
            pred_reg <= $unsigned(predicted_class);
            qry_reg  <= query_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_rd_reg <= 1'b0;
        else if (in_accept)
            valid_rd_reg <= cell_valid_reg[rd_addr];
    end

    // A cell never written since reset or clear reads as zero.
    assign cell_value = valid_rd_reg ? ram_rdata : '0;

    assign a_idx   = to_class(act_reg[3:0]);
    assign p_idx   = to_class(pred_reg[3:0]);
    assign q_idx   = to_class(qry_reg);
    assign wr_addr = cell_addr(a_idx, p_idx);
    assign q_ext   = CFG_W'(qry_reg);
    assign lim     = (cfg.actual_classes > cfg.predicted_classes) ?
                     cfg.actual_classes : cfg.predicted_classes;

    always_comb
    begin
        priority if (act_reg[LABEL_W-1] || pred_reg[LABEL_W-1])
            pair_status = STAT_UNKNOWN;
        else if (act_reg >= cfg.actual_classes || pred_reg >= cfg.predicted_classes)
            pair_status = STAT_RANGE;
        else
            pair_status = STAT_DONE;
    end

    assign ram_we = finish && op_reg == OP_ACCUM && pair_status == STAT_DONE;

    always_comb
    begin
        tot_cmd.clear   = finish && op_reg == OP_CLEAR;
        tot_cmd.inc     = ram_we;
        tot_cmd.row_idx = (op_reg == OP_QUERY) ? q_idx : a_idx;
        tot_cmd.col_idx = (op_reg == OP_QUERY) ? q_idx : p_idx;
        tot_cmd.diag    = (a_idx == p_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_valid_reg <= '0;
        else if (tot_cmd.clear)
            cell_valid_reg <= '0;
        else if (ram_we)
            cell_valid_reg[wr_addr] <= 1'b1;
    end

    // Result fields; anything the operation does not define stays zero.
    always_comb
    begin
        status_next    = STAT_DONE;
        cell_out_next  = '0;
        cdiag_out_next = '0;
        row_out_next   = '0;
        col_out_next   = '0;
        dtot_out_next  = '0;
        gtot_out_next  = '0;
        unique case (op_reg)
            OP_ACCUM: status_next = pair_status;
            OP_CLEAR: status_next = STAT_DONE;
            OP_QUERY:
            begin
                if (q_ext >= lim)
                    status_next = STAT_RANGE;
                else
                begin
                    if (q_ext < cfg.actual_classes && q_ext < cfg.predicted_classes)
                        cdiag_out_next = to_out(cell_value);
                    row_out_next  = to_out(tot.row);
                    col_out_next  = to_out(tot.col);
                    dtot_out_next = to_out(tot.diag);
                    gtot_out_next = to_out(tot.total);
                end
            end
            OP_READ:
            begin
                status_next = pair_status;
                if (pair_status == STAT_DONE)
                    cell_out_next = to_out(cell_value);
            end
            default: status_next = STAT_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg    <= status_next;
            cell_out_reg  <= cell_out_next;
            cdiag_out_reg <= cdiag_out_next;
            row_out_reg   <= row_out_next;
            col_out_reg   <= col_out_next;
            dtot_out_reg  <= dtot_out_next;
            gtot_out_reg  <= gtot_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign cell_count     = cell_out_reg;
    assign class_diagonal = cdiag_out_reg;
    assign row_total      = row_out_reg;
    assign column_total   = col_out_reg;
    assign diagonal_total = dtot_out_reg;
    assign grand_total    = gtot_out_reg;

    // A new result only appears after an operation has been worked on.
    a_rose_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without a request in progress");

    // The cell RAM is only written while a request is being worked on.
    a_we_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_EXEC)
        else $error("cell RAM written outside of a request");

    // Clear leaves every cell reading as zero.
    a_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tot_cmd.clear |=> cell_valid_reg == '0)
        else $error("cell valid bits survive a clear");

    // Any non-done status carries an all-zero payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_DONE) |->
        (cell_count == '0 && class_diagonal == '0 && row_total == '0 &&
         column_total == '0 && diagonal_total == '0 && grand_total == '0))
        else $error("payload not zero on an error status");

    // No request is accepted while another one is in progress.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_accept)
        else $error("second request accepted while busy");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for confusion_matrix_accumulator_unit: a directed request table, then random
// phases under several class limits, checked against a scoreboard model of the table or typed-in results.
// Depends on cma_pkg and the RTL of the block; reads no files.
module tb_top;
    import cma_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 184;
    localparam int DIRECTED_ROWS  = 26;
    localparam int SHRINK_ROW     = 17;

    typedef struct packed {
        status_t     status;
        logic [31:0] cell_count;
        logic [31:0] class_diagonal;
        logic [31:0] row_total;
        logic [31:0] column_total;
        logic [31:0] diagonal_total;
        logic [31:0] grand_total;
    } tally_t;

    typedef struct {
        op_t               op;
        logic signed [4:0] actual;
        logic signed [4:0] predicted;
        logic [3:0]        query;
        bit                typed;
        status_t           status;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                operation;
    logic signed [4:0]         actual_class;
    logic signed [4:0]         predicted_class;
    logic [3:0]                query_class;
    logic                      out_valid;
    logic                      out_stall;
    logic [1:0]                status;
    logic [31:0]               cell_count;
    logic [31:0]               class_diagonal;
    logic [31:0]               row_total;
    logic [31:0]               column_total;
    logic [31:0]               diagonal_total;
    logic [31:0]               grand_total;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_AW-1:0]         paddr;
    logic [APB_DW-1:0]         pwdata;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Scoreboard copy of the count table, its running totals and the class limits.
    logic [31:0] cells [MAX_CLASSES][MAX_CLASSES];
    logic [31:0] row_counts [MAX_CLASSES];
    logic [31:0] col_counts [MAX_CLASSES];
    logic [31:0] diag_count;
    logic [31:0] sample_count;
    int          rows_in_use;
    int          cols_in_use;

    tally_t pending_tallies [$];
    int     errors      = 0;
    int     idle_cycles = 0;
    bit     long_hold   = 1'b0;
    bit     steady      = 1'b0;
    int     burst_left  = 0;

    // Expected results are typed in only for rows whose answer is all zero apart from status.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_READ,  5'sd0,   5'sd0,   4'd0,  1'b1, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd0,  1'b1, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd15, 1'b1, STAT_DONE},
        '{OP_ACCUM, 5'sd0,   5'sd0,   4'd0,  1'b1, STAT_DONE},
        '{OP_ACCUM, 5'sd15,  5'sd15,  4'd0,  1'b1, STAT_DONE},
        '{OP_ACCUM, 5'sd15,  5'sd0,   4'd9,  1'b1, STAT_DONE},
        '{OP_ACCUM, 5'sh1F,  5'sd3,   4'd0,  1'b1, STAT_UNKNOWN},
        '{OP_ACCUM, 5'sd3,   5'sh10,  4'd0,  1'b1, STAT_UNKNOWN},
        '{OP_ACCUM, 5'sh10,  5'sh1F,  4'd0,  1'b1, STAT_UNKNOWN},
        '{OP_READ,  5'sh1F,  5'sd0,   4'd0,  1'b1, STAT_UNKNOWN},
        '{OP_READ,  5'sd0,   5'sd0,   4'd0,  1'b0, STAT_DONE},
        '{OP_READ,  5'sd15,  5'sd15,  4'd0,  1'b0, STAT_DONE},
        '{OP_READ,  5'sd15,  5'sd0,   4'd0,  1'b0, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd0,  1'b0, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd15, 1'b0, STAT_DONE},
        '{OP_ACCUM, 5'sd7,   5'sd9,   4'd0,  1'b0, STAT_DONE},
        '{OP_QUERY, 5'sd9,   5'sd7,   4'd7,  1'b0, STAT_DONE},
        // From here on the limits are four rows and two columns.
        '{OP_ACCUM, 5'sd4,   5'sd0,   4'd0,  1'b1, STAT_RANGE},
        '{OP_ACCUM, 5'sd0,   5'sd2,   4'd0,  1'b1, STAT_RANGE},
        '{OP_READ,  5'sd15,  5'sd15,  4'd0,  1'b1, STAT_RANGE},
        '{OP_ACCUM, 5'sd3,   5'sd1,   4'd0,  1'b0, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd4,  1'b1, STAT_RANGE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd3,  1'b0, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd15, 1'b1, STAT_RANGE},
        '{OP_CLEAR, 5'sd0,   5'sd0,   4'd0,  1'b1, STAT_DONE},
        '{OP_QUERY, 5'sd0,   5'sd0,   4'd1,  1'b1, STAT_DONE}
    };

    confusion_matrix_accumulator_unit i_dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp_limit(logic [31:0] value);
        int v;
        v = int'(value[4:0]);
        if (v == 0)
            v = 1;
        if (v > MAX_CLASSES)
            v = MAX_CLASSES;
        return v;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic void clear_counts();
        for (int r = 0; r < MAX_CLASSES; r++)
        begin
            for (int c = 0; c < MAX_CLASSES; c++)
                cells[r][c] = '0;
            row_counts[r] = '0;
            col_counts[r] = '0;
        end
        diag_count   = '0;
        sample_count = '0;
    endfunction

    // The unknown-label test comes before the range test.
    function automatic status_t label_status(logic signed [4:0] a, logic signed [4:0] p);
        if (a[4] || p[4])
            return STAT_UNKNOWN;
        if (int'(a[3:0]) >= rows_in_use || int'(p[3:0]) >= cols_in_use)
            return STAT_RANGE;
        return STAT_DONE;
    endfunction

    function automatic tally_t update_matrix(op_t op, logic signed [4:0] a,
                                             logic signed [4:0] p, logic [3:0] q);
        tally_t t;
        int     ri;
        int     ci;
        int     qi;
        int     lim;
        t  = '0;
        ri = int'(a[3:0]);
        ci = int'(p[3:0]);
        qi = int'(q);
        case (op)
            OP_ACCUM:
            begin
                t.status = label_status(a, p);
                if (t.status == STAT_DONE)
                begin
                    cells[ri][ci] = bump(cells[ri][ci]);
                    row_counts[ri] = bump(row_counts[ri]);
                    col_counts[ci] = bump(col_counts[ci]);
                    if (ri == ci)
                        diag_count = bump(diag_count);
                    sample_count = bump(sample_count);
                end
            end
            OP_CLEAR:
                clear_counts();
            OP_QUERY:
            begin
                lim = (rows_in_use > cols_in_use) ? rows_in_use : cols_in_use;
                if (qi >= lim)
                    t.status = STAT_RANGE;
                else
                begin
                    // Stored totals are returned even for a class beyond one of the limits.
                    if (qi < rows_in_use && qi < cols_in_use)
                        t.class_diagonal = cells[qi][qi];
                    t.row_total      = row_counts[qi];
                    t.column_total   = col_counts[qi];
                    t.diagonal_total = diag_count;
                    t.grand_total    = sample_count;
                end
            end
            default:
            begin
                t.status = label_status(a, p);
                if (t.status == STAT_DONE)
                    t.cell_count = cells[ri][ci];
            end
        endcase
        return t;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [4:0] pick_label(int limit);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 5'($urandom_range(0, limit - 1));
        if (r < 93)
            return 5'($urandom_range(0, 15));
        return 5'($urandom_range(16, 31));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_request(op_t op, logic signed [4:0] a, logic signed [4:0] p,
                                logic [3:0] q, bit typed, status_t typed_status);
        int     gap;
        tally_t t;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if (steady)
            gap = 0;
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        operation       <= op;
        actual_class    <= a;
        predicted_class <= p;
        query_class     <= q;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        t = update_matrix(op, a, p, q);
        if (typed)
        begin
            t        = '0;
            t.status = typed_status;
        end
        pending_tallies = {pending_tallies, t};
    endtask

    task automatic send_random();
        op_t               op;
        logic signed [4:0] a;
        logic signed [4:0] p;
        logic [3:0]        q;
        int                r;
        int                lim;
        r  = $urandom_range(0, 99);
        op = (r < 60) ? OP_ACCUM : (r < 78) ? OP_READ : (r < 99) ? OP_QUERY : OP_CLEAR;
        a  = pick_label(rows_in_use);
        p  = pick_label(cols_in_use);
        // Lean toward the diagonal so that its totals move.
        if ($urandom_range(0, 3) == 0 && !a[4] && int'(a[3:0]) < cols_in_use)
            p = a;
        lim = (rows_in_use > cols_in_use) ? rows_in_use : cols_in_use;
        if ($urandom_range(0, 99) < 80)
            q = 4'($urandom_range(0, lim - 1));
        else
            q = 4'($urandom_range(0, 15));
        send_request(op, a, p, q, 1'b0, STAT_DONE);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tallies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_register(logic idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ACTUAL)
            rows_in_use = clamp_limit(value);
        else
            cols_in_use = clamp_limit(value);
    endtask

    // Result side: random stalls, plus one long hold on request from the stimulus.
    initial
    begin : result_side
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else
            begin
                n = steady ? 0 : pick_gap();
                if (n > 0)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                    repeat (n - 1) @(negedge clk);
                end
                @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        tally_t want;
        if (out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_tallies.size() == 0)
            begin
                $error("result with status %0d arrived with nothing outstanding", status);
                errors++;
            end
            else
            begin
                want = pending_tallies.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("cell_count", want.cell_count, cell_count);
                check_field("class_diagonal", want.class_diagonal, class_diagonal);
                check_field("row_total", want.row_total, row_total);
                check_field("column_total", want.column_total, column_total);
                check_field("diagonal_total", want.diagonal_total, diagonal_total);
                check_field("grand_total", want.grand_total, grand_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] rows_value;
        logic [31:0] cols_value;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        operation       = OP_ACCUM;
        actual_class    = '0;
        predicted_class = '0;
        query_class     = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rows_in_use     = MAX_CLASSES;
        cols_in_use     = MAX_CLASSES;
        clear_counts();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            // Shrink the limits with counts still stored beyond them.
            if (i == SHRINK_ROW)
            begin
                wait_idle();
                program_register(REG_ACTUAL, 32'd4);
                program_register(REG_PREDICTED, 32'd2);
            end
            send_request(directed_rows[i].op, directed_rows[i].actual,
                         directed_rows[i].predicted, directed_rows[i].query,
                         directed_rows[i].typed, directed_rows[i].status);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    rows_value = 32'd16;
                    cols_value = 32'd16;
                end
                1:
                begin
                    rows_value = 32'd1;
                    cols_value = 32'd1;
                end
                2:
                begin
                    rows_value = 32'd16;
                    cols_value = 32'd1;
                end
                3:
                begin
                    // Zero acts as one and anything above the maximum as the maximum.
                    rows_value = 32'd0;
                    cols_value = 32'd31;
                end
                4:
                begin
                    rows_value = 32'd1;
                    cols_value = 32'd16;
                end
                default:
                begin
                    rows_value = 32'($urandom_range(0, 31));
                    cols_value = 32'($urandom_range(0, 31));
                end
            endcase
            if (ph == PHASES - 1)
            begin
                rows_value = rows_value | ($urandom() & 32'hFFFF_FFE0);
                cols_value = cols_value | ($urandom() & 32'hFFFF_FFE0);
            end
            program_register(REG_ACTUAL, rows_value);
            program_register(REG_PREDICTED, cols_value);
            steady = (ph == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Back-to-back requests against a stalled result side fill the block.
                if (ph == 2 && i == 30)
                begin
                    long_hold  = 1'b1;
                    burst_left = 40;
                end
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    wait_idle();
                send_random();
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
